// File: src/assert_macros.svh
// assert_macros.svh: shared concurrent assertion macros for the pacer RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define SSP_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// same-cycle implication
`define SSP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ssp_pkg.sv
// ssp_pkg: types, widths, opcodes and the client tier table of the pacer.
// No dependencies; used by every module of the block.
package ssp_pkg;

	localparam int STEP_W  = 10;
	localparam int CAP_W   = 16;
	localparam int K_W     = 12;
	localparam int PROD_W  = STEP_W + K_W;
	localparam int CNT16_W = 16;
	localparam int ACC_W   = 17;
	localparam int SLOT_W  = 32;
	localparam int PEND_W  = 5;
	localparam int DIVC_W  = $clog2(PROD_W + 1);

	localparam int IN_W    = 80;
	localparam int OUT_W   = 72;
	localparam int APB_AW  = 3;

	// opcodes carried on tuser
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RAISE = 2'd1;
	localparam logic [1:0] OP_SKIP  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// register index (paddr[2])
	localparam logic REG_STEP_MS  = 1'b0;
	localparam logic REG_DIFF_CAP = 1'b1;

	localparam logic [STEP_W-1:0] STEP_MS_RST  = 10'd120;
	localparam logic [CAP_W-1:0]  DIFF_CAP_RST = 16'd60000;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} ssp_qcmd_t;

	// tier factor by client count
	function automatic logic [K_W-1:0] tier_k(input logic [CNT16_W-1:0] count);
		logic [K_W-1:0] k;
		if (count <= 16'd1500)      k = 12'd1000;
		else if (count <= 16'd2500) k = 12'd1500;
		else if (count <= 16'd2750) k = 12'd2000;
		else if (count <= 16'd3000) k = 12'd3000;
		else if (count <= 16'd3250) k = 12'd3500;
		else                        k = 12'd4000;
		return k;
	endfunction

endpackage

// File: src/ssp_div.sv
// ssp_div: restoring divider, one quotient bit per cycle.
// Depends on ssp_pkg for widths.
module ssp_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [ssp_pkg::PROD_W-1:0]      dividend,
	input  logic [ssp_pkg::CNT16_W-1:0]     divisor,
	output logic                            done,
	output logic [ssp_pkg::PROD_W-1:0]      quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic [ssp_pkg::DIVC_W-1:0]     cnt_q;
	logic [ssp_pkg::CNT16_W-1:0]    rem_q;
	logic [ssp_pkg::PROD_W-1:0]     quo_q;
	logic [ssp_pkg::CNT16_W:0]      shifted;
	logic                           fits;

	assign shifted = {rem_q, quo_q[ssp_pkg::PROD_W-1]};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ssp_pkg::DIVC_W'(ssp_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ssp_pkg::DIVC_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? ssp_pkg::CNT16_W'(shifted - {1'b0, divisor})
			              : shifted[ssp_pkg::CNT16_W-1:0];
			quo_q <= {quo_q[ssp_pkg::PROD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: src/ssp_queue.sv
// ssp_queue: circular skip-value queue held in a RAM with registered head read.
// Depends on ssp_pkg (command struct) and assert_macros.svh.
`include "assert_macros.svh"

module ssp_queue #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssp_pkg::ssp_qcmd_t            cmd,
	input  logic [ssp_pkg::SLOT_W-1:0]    push_data,
	output logic [ssp_pkg::SLOT_W-1:0]    head_data,
	output logic [$clog2(DEPTH+1)-1:0]    count
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	logic [ssp_pkg::SLOT_W-1:0] mem_q [DEPTH];
	logic [ssp_pkg::SLOT_W-1:0] rd_q;
	logic [IDX_W-1:0]           head_q;
	logic [CNT_W-1:0]           count_q;
	logic [SUM_W-1:0]           tail_sum;
	logic [SUM_W-1:0]           tail_wrap;
	logic [IDX_W-1:0]           tail;

	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
	assign tail      = tail_wrap[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop) begin
			head_q  <= (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[tail] <= push_data;
		end
		rd_q <= mem_q[head_q];
	end

	assign head_data = rd_q;
	assign count     = count_q;

	`SSP_ASSERT_IMPLY(a_pop_nonempty, clk, arst_n, cmd.pop, count_q != '0, "pop from empty queue")
	`SSP_ASSERT_IMPLY(a_push_notfull, clk, arst_n, cmd.push, count_q != CNT_W'(DEPTH), "push to full queue")
	`SSP_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// File: src/save_slot_pacer_top.sv
// save_slot_pacer_top: serving-counter pacer with APB registers and stream ports.
// Depends on ssp_pkg, ssp_div, ssp_queue and assert_macros.svh.
//
// The block takes one operation per input transfer and returns exactly one result
// transfer for it, showing the counter, ceiling, queue fill and a drop flag after
// the operation. Raise, skip push and the unused opcode go from decode straight to the
// output. A tick with headroom and clients first sets up (one multiply for step_ms
// times the tier factor, then a restoring divide by the client count), then runs
// TEST, ADV, CHK and UPD per interval advanced and RD per skip value popped:
// the advance loop runs on one compare/subtract datapath under the sequencer and
// reads the skip queue head from a RAM with a registered read port. s_tready is high
// only while the sequencer is idle; a finished result sits in the output register,
// so the next transfer can be taken while that result waits for m_tready.
// Registers: step_ms at byte 0x0, diff_cap at byte 0x4; they should be written only
// while no operation is in flight. The skip queue RAM needs no clearing after reset.
`include "assert_macros.svh"

module save_slot_pacer_top #(
	parameter int SKIP_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ssp_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [15:0] elapsed_ms, [31:16] client_count, [47:32] amount, [79:48] skip_value
	input  logic [ssp_pkg::IN_W-1:0]     s_tdata,
	// [1:0] opcode
	input  logic [1:0]                   s_tuser,
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [31:0] current_slot, [63:32] ceiling_slot, [68:64] pending_skips,
	// [69] dropped, [71:70] zero
	output logic [ssp_pkg::OUT_W-1:0]    m_tdata
);

	localparam int CNT_W  = $clog2(SKIP_DEPTH + 1);
	localparam int SLOT_W = ssp_pkg::SLOT_W;
	localparam int ACC_W  = ssp_pkg::ACC_W;
	localparam int PROD_W = ssp_pkg::PROD_W;

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_EXEC   = 4'd1;  // decode op; tick: compare ceiling/counter
	localparam logic [3:0] ST_T1     = 4'd2;  // clear or clamp, multiply, accumulate
	localparam logic [3:0] ST_DSTART = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_TEST   = 4'd5;  // accumulator >= interval ?
	localparam logic [3:0] ST_ADV    = 4'd6;  // counter + 1
	localparam logic [3:0] ST_CHK    = 4'd7;  // compare queue head, maybe pop
	localparam logic [3:0] ST_RD     = 4'd8;  // wait for the new head read
	localparam logic [3:0] ST_UPD    = 4'd9;  // take one interval off, cap or stop
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0]                    state_q;

	// configuration
	logic [ssp_pkg::STEP_W-1:0]    step_ms_q;
	logic [ssp_pkg::CAP_W-1:0]     diff_cap_q;
	logic                          cfg_wr;

	// captured operation
	logic [1:0]                    op_q;
	logic [15:0]                   elapsed_q;
	logic [ssp_pkg::CNT16_W-1:0]   clients_q;
	logic [15:0]                   amount_q;
	logic [SLOT_W-1:0]             skip_val_q;

	// architectural state
	logic [SLOT_W-1:0]             ctr_q;
	logic [SLOT_W-1:0]             ceil_q;
	logic [ACC_W-1:0]              acc_q;

	// working registers
	logic                          gt_q;
	logic [SLOT_W-1:0]             diff_q;
	logic [PROD_W-1:0]             prod_q;
	logic [PROD_W-1:0]             interval_q;
	logic                          dropped_q;

	// output register
	logic                          m_tvalid_q;
	logic [ssp_pkg::OUT_W-1:0]     m_tdata_q;

	// datapath nets
	logic                          in_acc;
	logic                          out_load;
	logic [ACC_W:0]                acc_sum;
	logic [ACC_W-1:0]              acc_sat;
	logic [SLOT_W-1:0]             addend;
	logic [ACC_W-1:0]              acc_sub;
	logic [ACC_W-1:0]              acc_capped;
	logic                          head_le;
	logic                          skip_full;
	logic                          div_done;
	logic [PROD_W-1:0]             div_q;
	ssp_pkg::ssp_qcmd_t            qcmd;
	logic [SLOT_W-1:0]             head_data;
	logic [CNT_W-1:0]              skip_cnt;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		case (paddr[2])
			ssp_pkg::REG_STEP_MS:  prdata = 32'(step_ms_q);
			ssp_pkg::REG_DIFF_CAP: prdata = 32'(diff_cap_q);
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ms_q  <= ssp_pkg::STEP_MS_RST;
			diff_cap_q <= ssp_pkg::DIFF_CAP_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				ssp_pkg::REG_STEP_MS:  step_ms_q  <= pwdata[ssp_pkg::STEP_W-1:0];
				ssp_pkg::REG_DIFF_CAP: diff_cap_q <= pwdata[ssp_pkg::CAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// accumulator saturates at the 17-bit maximum
	assign acc_sum    = {1'b0, acc_q} + (ACC_W + 1)'(elapsed_q);
	assign acc_sat    = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	// headroom the ceiling may keep above the counter
	assign addend     = SLOT_W'(clients_q) + SLOT_W'(skip_cnt);
	// only used once acc_q >= interval_q, so the interval fits the accumulator
	assign acc_sub    = acc_q - interval_q[ACC_W-1:0];
	assign acc_capped = (acc_sub > ACC_W'(diff_cap_q)) ? ACC_W'(diff_cap_q) : acc_sub;
	assign head_le    = (skip_cnt != '0) && (head_data <= ctr_q);
	assign skip_full  = (skip_cnt == CNT_W'(SKIP_DEPTH));

	always_comb begin
		qcmd.push  = (state_q == ST_EXEC) && (op_q == ssp_pkg::OP_SKIP) && !skip_full;
		qcmd.pop   = (state_q == ST_CHK) && head_le;
		qcmd.clear = (state_q == ST_T1) && gt_q && (clients_q == '0);
	end

	ssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DSTART),
		.dividend (prod_q),
		.divisor  (clients_q),
		.done     (div_done),
		.quotient (div_q)
	);

	ssp_queue #(
		.DEPTH (SKIP_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (qcmd),
		.push_data (skip_val_q),
		.head_data (head_data),
		.count     (skip_cnt)
	);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ctr_q      <= '0;
			ceil_q     <= '0;
			acc_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op_q == ssp_pkg::OP_TICK) begin
						state_q <= ST_T1;
					end else begin
						if (op_q == ssp_pkg::OP_RAISE) begin
							ceil_q <= ceil_q + SLOT_W'(amount_q);
						end
						state_q <= ST_OUT;
					end
				end
				ST_T1: begin
					if (!gt_q) begin
						state_q <= ST_OUT;
					end else if (clients_q == '0) begin
						ctr_q   <= '0;
						ceil_q  <= '0;
						acc_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						if (diff_q > addend) begin
							ceil_q <= ctr_q + addend;
						end
						acc_q   <= acc_sat;
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					state_q <= (PROD_W'(acc_q) >= interval_q) ? ST_ADV : ST_OUT;
				end
				ST_ADV: begin
					ctr_q   <= ctr_q + 1'b1;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (head_le) begin
						ctr_q   <= ctr_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_UPD: begin
					if (ctr_q > ceil_q) begin
						acc_q   <= '0;
						state_q <= ST_OUT;
					end else begin
						acc_q   <= acc_capped;
						state_q <= ST_TEST;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q       <= s_tuser;
			elapsed_q  <= s_tdata[15:0];
			clients_q  <= s_tdata[31:16];
			amount_q   <= s_tdata[47:32];
			skip_val_q <= s_tdata[79:48];
			dropped_q  <= 1'b0;
		end
		if (state_q == ST_EXEC) begin
			gt_q   <= ceil_q > ctr_q;
			diff_q <= ceil_q - ctr_q;
			if ((op_q == ssp_pkg::OP_SKIP) && skip_full) begin
				dropped_q <= 1'b1;
			end
		end
		if (state_q == ST_T1) begin
			prod_q <= PROD_W'(step_ms_q) * PROD_W'(ssp_pkg::tier_k(clients_q));
		end
		if ((state_q == ST_DIV) && div_done) begin
			interval_q <= (div_q == '0) ? PROD_W'(1) : div_q;
		end
		if (out_load) begin
			m_tdata_q <= {2'b00, dropped_q, ssp_pkg::PEND_W'(skip_cnt), ceil_q, ctr_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SSP_ASSERT_IMPLY(a_adv_due, clk, arst_n, state_q == ST_ADV, PROD_W'(acc_q) >= interval_q, "advance without a full interval")
	`SSP_ASSERT_NEXT(a_adv_inc, clk, arst_n, state_q == ST_ADV, ctr_q == $past(ctr_q) + 32'd1, "advance did not step the counter")
	`SSP_ASSERT_IMPLY(a_int_nz, clk, arst_n, state_q == ST_TEST, interval_q != '0, "zero interval in advance loop")

endmodule

// File: sim/save_slot_pacer_top_test.sv
`timescale 1ns / 1ps
// save_slot_pacer_top_test: self-checking bench for the serving-counter pacer.
// Depends on ssp_pkg and save_slot_pacer_top; predicts every result transfer in-bench
// and checks the result stream against it, with both sides idling at random in most stretches.
module save_slot_pacer_top_test;

	localparam int unsigned ACC_SAT     = 131071;  // 17-bit accumulator saturation
	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int          SETTLE_CYC  = 200;     // quiet cycles after the last result
	localparam int          BACKLOG_MAX = 3;       // keeps skip values near the live counter

	// one operation as it travels on the input stream
	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] elapsed_ms;
		logic [15:0] client_count;
		logic [15:0] amount;
		logic [31:0] skip_value;
	} slot_op_t;

	// one result transfer, decoded
	typedef struct packed {
		logic [31:0] current_slot;
		logic [31:0] ceiling_slot;
		logic [4:0]  pending_skips;
		logic        dropped;
	} slot_report_t;

	logic                       clk      = 1'b0;
	logic                       arst_n   = 1'b0;
	logic                       psel     = 1'b0;
	logic                       penable  = 1'b0;
	logic                       pwrite   = 1'b0;
	logic [ssp_pkg::APB_AW-1:0] paddr    = '0;
	logic [31:0]                pwdata   = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       s_tvalid = 1'b0;
	logic                       s_tready;
	logic [ssp_pkg::IN_W-1:0]   s_tdata  = '0;
	logic [1:0]                 s_tuser  = ssp_pkg::OP_NOP;
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [ssp_pkg::OUT_W-1:0]  m_tdata;

	save_slot_pacer_top #(
		.SKIP_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Pacer state as the bench sees it, plus the two registers.
	// ---------------------------------------------------------------
	logic [31:0]  pace_counter = '0;
	logic [31:0]  pace_ceiling = '0;
	int unsigned  pace_accum   = 0;
	logic [31:0]  skip_fifo[$];
	logic [9:0]   cfg_step_ms  = ssp_pkg::STEP_MS_RST;
	logic [15:0]  cfg_diff_cap = ssp_pkg::DIFF_CAP_RST;

	slot_op_t     op_backlog[$];   // waiting for the driver
	slot_report_t report_due[$];   // predicted, not yet seen on the result stream
	slot_op_t     op_on_bus;       // transfer currently offered on the input side
	bit           send_idling = 1'b1;
	bit           recv_idling = 1'b1;
	int           mismatches  = 0;

	// client-count tiers: larger crowds get a longer per-client interval
	function automatic int unsigned tier_scale(input logic [15:0] count);
		if (count <= 16'd1500) return 1000;
		if (count <= 16'd2500) return 1500;
		if (count <= 16'd2750) return 2000;
		if (count <= 16'd3000) return 3000;
		if (count <= 16'd3250) return 3500;
		return 4000;
	endfunction

	// applies one operation to the bench state and returns the report it causes
	function automatic slot_report_t pace_apply(input slot_op_t op);
		slot_report_t     rep;
		longint unsigned  interval;
		logic [31:0]      allowance;
		rep.dropped = 1'b0;
		case (op.opcode)
			ssp_pkg::OP_TICK: begin
				// a tick is dead unless there is headroom above the counter
				if (pace_ceiling > pace_counter) begin
					if (op.client_count == 16'd0) begin
						pace_counter = '0;
						pace_ceiling = '0;
						pace_accum   = 0;
						skip_fifo.delete();
					end else begin
						// clamp the ceiling to what the clients plus queued skips justify
						allowance = 32'(op.client_count) + 32'(skip_fifo.size());
						if (pace_ceiling - pace_counter > allowance)
							pace_ceiling = pace_counter + allowance;
						interval = (64'(cfg_step_ms) * tier_scale(op.client_count))
							/ op.client_count;
						if (interval == 0)
							interval = 1;
						pace_accum += 32'(op.elapsed_ms);
						if (pace_accum > ACC_SAT)
							pace_accum = ACC_SAT;
						while (pace_accum >= interval) begin
							pace_counter += 1;
							// hop over values already handed out; only the head is looked at
							while (skip_fifo.size() != 0 && skip_fifo[0] <= pace_counter) begin
								pace_counter += 1;
								skip_fifo.delete(0);
							end
							pace_accum -= 32'(interval);
							if (pace_counter > pace_ceiling) begin
								pace_accum = 0;
								break;
							end
							if (pace_accum > cfg_diff_cap)
								pace_accum = 32'(cfg_diff_cap);
						end
					end
				end
			end
			ssp_pkg::OP_RAISE: begin
				pace_ceiling += 32'(op.amount);
			end
			ssp_pkg::OP_SKIP: begin
				if (skip_fifo.size() >= QUEUE_DEPTH)
					rep.dropped = 1'b1;
				else
					skip_fifo.push_back(op.skip_value);
			end
			default: begin
			end
		endcase
		rep.current_slot  = pace_counter;
		rep.ceiling_slot  = pace_ceiling;
		rep.pending_skips = 5'(skip_fifo.size());
		return rep;
	endfunction

	// ---------------------------------------------------------------
	// Input side: the prediction is taken at the edge where the transfer
	// happens, so it always sees the registers as the block does.
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				report_due.push_back(pace_apply(op_on_bus));
			if (!s_tvalid || s_tready) begin
				if (op_backlog.size() != 0 && !(send_idling && $urandom_range(0, 99) < 38)) begin
					op_on_bus = op_backlog[0];
					op_backlog.delete(0);
					s_tvalid <= 1'b1;
					s_tdata  <= {op_on_bus.skip_value, op_on_bus.amount,
						op_on_bus.client_count, op_on_bus.elapsed_ms};
					s_tuser  <= op_on_bus.opcode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(recv_idling && $urandom_range(0, 99) < 38);
		end
	end

	// result checker: each transfer against the oldest prediction
	always @(posedge clk) begin
		slot_report_t seen;
		slot_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			seen.current_slot  = m_tdata[31:0];
			seen.ceiling_slot  = m_tdata[63:32];
			seen.pending_skips = m_tdata[68:64];
			seen.dropped       = m_tdata[69];
			if (report_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: %s %0d ceiling %0d pending %0d drop %0b",
						"slot", seen.current_slot, seen.ceiling_slot,
						seen.pending_skips, seen.dropped);
			end else begin
				want = report_due[0];
				report_due.delete(0);
				if (seen.current_slot !== want.current_slot
					|| seen.ceiling_slot !== want.ceiling_slot
					|| seen.pending_skips !== want.pending_skips
					|| seen.dropped !== want.dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch at %0t: slot %0d/%0d ceiling %0d/%0d ",
							"pending %0d/%0d drop %0b/%0b (exp/act)"},
							$realtime, want.current_slot, seen.current_slot,
							want.ceiling_slot, seen.ceiling_slot,
							want.pending_skips, seen.pending_skips, want.dropped, seen.dropped);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic slot_op_t make_op(input logic [1:0] opc, input logic [15:0] elapsed,
		input logic [15:0] count, input logic [15:0] amt, input logic [31:0] skip);
		slot_op_t op;
		op.opcode       = opc;
		op.elapsed_ms   = elapsed;
		op.client_count = count;
		op.amount       = amt;
		op.skip_value   = skip;
		return op;
	endfunction

	// skip value mostly just ahead of the live counter so the loop has to hop it
	function automatic logic [31:0] pick_skip();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 75) return pace_counter + $urandom_range(0, 24);
		if (roll < 92) return pace_counter - $urandom_range(0, 8);
		return $urandom;
	endfunction

	// unused fields carry random junk the block must ignore
	function automatic slot_op_t random_op();
		slot_op_t    op;
		int unsigned roll;
		op = make_op(ssp_pkg::OP_NOP, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			op.opcode = ssp_pkg::OP_TICK;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				op.client_count = 16'd0;
			else if (roll < 72)
				op.client_count = 16'($urandom_range(1, 40));
			else if (roll < 90)
				op.client_count = 16'($urandom_range(1000, 4000));
			op.elapsed_ms = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 400))
				: 16'($urandom);
		end else if (roll < 70) begin
			op.opcode = ssp_pkg::OP_RAISE;
			if ($urandom_range(0, 99) >= 3)
				op.amount = 16'($urandom_range(0, 60));
		end else if (roll < 95) begin
			op.opcode     = ssp_pkg::OP_SKIP;
			op.skip_value = pick_skip();
		end
		return op;
	endfunction

	task automatic queue_op(input slot_op_t op);
		while (op_backlog.size() > BACKLOG_MAX)
			@(negedge clk);
		op_backlog.push_back(op);
	endtask

	// run of skip pushes long enough to overflow the queue
	task automatic skip_burst();
		repeat (QUEUE_DEPTH + 2)
			queue_op(make_op(ssp_pkg::OP_SKIP, 16'($urandom), 16'($urandom), 16'($urandom),
				pick_skip()));
	endtask

	task automatic random_phase(input int target);
		int made;
		made = 0;
		while (made < target) begin
			if ($urandom_range(0, 99) < 3) begin
				skip_burst();
				made += QUEUE_DEPTH + 2;
			end else begin
				queue_op(random_op());
				made++;
			end
		end
	endtask

	// sender holds off until every predicted result has been taken
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (op_backlog.size() != 0 || s_tvalid || report_due.size() != 0);
	endtask

	// APB write: setup then access; lands at the edge where pready is seen high
	task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == ssp_pkg::REG_STEP_MS)
			cfg_step_ms = value[9:0];
		else
			cfg_diff_cap = value[15:0];
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values; directed corners first
		queue_op(make_op(ssp_pkg::OP_NOP, '1, '1, '1, '1));
		// no headroom: dead tick
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd100, 16'd0, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_RAISE, 16'd0, 16'd0, 16'hFFFF, 32'd0));
		queue_op(make_op(ssp_pkg::OP_SKIP, 16'd0, 16'd0, 16'd0, 32'd3));
		queue_op(make_op(ssp_pkg::OP_SKIP, 16'd0, 16'd0, 16'd0, 32'd5));
		queue_op(make_op(ssp_pkg::OP_SKIP, 16'd0, 16'd0, 16'd0, 32'd0));
		// interval above one elapsed value: clamps ceiling, then builds the
		// accumulator up to one advance of the counter
		repeat (3)
			queue_op(make_op(ssp_pkg::OP_TICK, 16'hFFFF, 16'd1, 16'd0, 32'd0));
		// top tier, tiny interval
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd1000, 16'hFFFF, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd50, 16'd5, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_RAISE, 16'd0, 16'd0, 16'd30, 32'd0));
		// both sides of every tier edge
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd1500, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd1501, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd2500, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd2501, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd2750, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd2751, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd3000, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd3001, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd3250, 16'd0, 32'd0));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd200, 16'd3251, 16'd0, 32'd0));
		// unreachable skip value, then a zero-client tick clears everything
		queue_op(make_op(ssp_pkg::OP_RAISE, 16'd0, 16'd0, 16'd5, 32'd0));
		queue_op(make_op(ssp_pkg::OP_SKIP, 16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));
		queue_op(make_op(ssp_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 32'd0));

		// guaranteed overflow of the skip queue, then random traffic
		queue_op(make_op(ssp_pkg::OP_RAISE, 16'd0, 16'd0, 16'd40, 32'd0));
		skip_burst();
		random_phase(20);
		wait_quiet();

		// shortest intervals, accumulator held at zero after every advance
		cfg_write(ssp_pkg::REG_STEP_MS, 32'd1);
		cfg_write(ssp_pkg::REG_DIFF_CAP, 32'd0);
		random_phase(25);
		wait_quiet();

		// longest intervals, widest cap; this stretch runs with no idling on either side
		send_idling = 1'b0;
		recv_idling = 1'b0;
		cfg_write(ssp_pkg::REG_STEP_MS, 32'd1023);
		cfg_write(ssp_pkg::REG_DIFF_CAP, 32'd65535);
		random_phase(25);
		wait_quiet();

		send_idling = 1'b1;
		recv_idling = 1'b1;
		cfg_write(ssp_pkg::REG_STEP_MS, 32'd300);
		cfg_write(ssp_pkg::REG_DIFF_CAP, 32'd500);
		random_phase(25);
		wait_quiet();

		// catch any stray result after the last expected one
		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && report_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// hang guard; worst-case tick loops are long, so this is generous
	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
